[sv/ethernet_l2_l3_l4_packet_filter_unit_macros.svh]
`ifndef ETHERNET_L2_L3_L4_PACKET_FILTER_UNIT_MACROS_SVH
`define ETHERNET_L2_L3_L4_PACKET_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PKF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("packet filter check failed");

// Next-cycle implication, disabled while reset is high.
`define PKF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("packet filter check failed");

`endif

[sv/pkf_pkg.sv]
`default_nettype none

package pkf_pkg;

  localparam int QUEUE_COUNT = 64;

  localparam logic [15:0] ET_VLAN    = 16'h8100;
  localparam logic [15:0] ET_IPV4    = 16'h0800;
  localparam logic [15:0] ET_IPV6    = 16'h86DD;
  localparam logic [15:0] ET_ARP     = 16'h0806;
  localparam logic [15:0] ET_LEN_MAX = 16'h0600;

  localparam logic [2:0] PH_ETH  = 3'd0;
  localparam logic [2:0] PH_VLAN = 3'd1;
  localparam logic [2:0] PH_LLC  = 3'd2;
  localparam logic [2:0] PH_SNAP = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;

  localparam logic [7:0] LLC_SAP   = 8'hAA;
  localparam logic [7:0] LLC_CTRL  = 8'h03;
  localparam logic [7:0] SNAP_ZERO = 8'h00;

  localparam logic [6:0] HS_ETH   = 7'd14;
  localparam logic [6:0] HS_VLAN  = 7'd18;
  localparam logic [6:0] SNAP_LEN = 7'd8;

  localparam logic [7:0] PROTO_ICMP   = 8'd1;
  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam logic [7:0] PROTO_UDP    = 8'd17;
  localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

  localparam logic [4:0] L4_TCP    = 5'b00001;
  localparam logic [4:0] L4_UDP    = 5'b00010;
  localparam logic [4:0] L4_ICMP   = 5'b00100;
  localparam logic [4:0] L4_ICMPV6 = 5'b01000;
  localparam logic [4:0] L4_OTHER  = 5'b10000;

  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_L2     = 3'd1;
  localparam logic [2:0] REG_L3     = 3'd2;
  localparam logic [2:0] REG_L4     = 3'd3;
  localparam logic [2:0] REG_SOCKET = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic [5:0] rx_queue;
  } in_word_t;

  typedef struct packed {
    logic       verdict;
    logic [5:0] queue_index;
  } out_word_t;

  typedef struct packed {
    logic        filter_enable;
    logic [2:0]  layer2_mask;
    logic [2:0]  layer3_mask;
    logic [4:0]  layer4_mask;
    logic [63:0] socket_bound_mask;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  byte_offset;
    logic [15:0] ether_type;
    logic        vlan_seen;
    logic [6:0]  header_start;
    logic        llc_snap_match;
    logic [5:0]  ip_header_bytes;
    logic [7:0]  l4_protocol;
    logic [5:0]  held_queue;
    logic [2:0]  l2_phase;
  } pkf_state_t;

endpackage

`default_nettype wire

[sv/pkf_regs.sv]
`default_nettype none

module pkf_regs
  import pkf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic [2:0] index;
  logic       wr;

  assign index  = paddr[5:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_enable     <= 1'b1;
      cfg.layer2_mask       <= '0;
      cfg.layer3_mask       <= '0;
      cfg.layer4_mask       <= '0;
      cfg.socket_bound_mask <= '0;
    end else if (wr) begin
      case (index)
        REG_ENABLE: cfg.filter_enable     <= pwdata[0];
        REG_L2:     cfg.layer2_mask       <= pwdata[2:0];
        REG_L3:     cfg.layer3_mask       <= pwdata[2:0];
        REG_L4:     cfg.layer4_mask       <= pwdata[4:0];
        REG_SOCKET: cfg.socket_bound_mask <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_ENABLE: prdata = {63'd0, cfg.filter_enable};
      REG_L2:     prdata = {61'd0, cfg.layer2_mask};
      REG_L3:     prdata = {61'd0, cfg.layer3_mask};
      REG_L4:     prdata = {59'd0, cfg.layer4_mask};
      REG_SOCKET: prdata = cfg.socket_bound_mask;
      default:    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[sv/pkf_parse.sv]
`default_nettype none

module pkf_parse
  import pkf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire in_word_t   item,
  output pkf_state_t      nxt
);

  pkf_state_t  state;
  pkf_state_t  fresh;
  logic [7:0]  p;
  logic [7:0]  b;
  logic [7:0]  k;
  logic [15:0] type_low;

  assign p        = state.byte_offset;
  assign b        = item.data_byte;
  assign k        = (p >= {1'b0, state.header_start}) ?
                    p - {1'b0, state.header_start} : 8'hFF;
  assign type_low = {state.ether_type[15:8], b};

  always_comb begin
    nxt = state;
    if (p == 8'd0) begin
      nxt.held_queue = item.rx_queue;
    end
    case (state.l2_phase)
      PH_ETH: begin
        if (p == 8'd12) nxt.ether_type = {b, 8'h00};
        if (p == 8'd13) begin
          nxt.ether_type = type_low;
          if (type_low == ET_VLAN) begin
            nxt.vlan_seen = 1'b1;
            nxt.l2_phase  = PH_VLAN;
          end else begin
            nxt.header_start   = HS_ETH;
            nxt.llc_snap_match = 1'b1;
            nxt.l2_phase       = (type_low <= ET_LEN_MAX) ? PH_LLC : PH_DONE;
          end
        end
      end
      PH_VLAN: begin
        if (p == 8'd16) nxt.ether_type = {b, 8'h00};
        if (p == 8'd17) begin
          nxt.ether_type     = type_low;
          nxt.header_start   = HS_VLAN;
          nxt.llc_snap_match = 1'b1;
          nxt.l2_phase       = (type_low <= ET_LEN_MAX) ? PH_LLC : PH_DONE;
        end
      end
      PH_LLC: begin
        if (k <= 8'd1 && b != LLC_SAP) nxt.llc_snap_match = 1'b0;
        if (k == 8'd2) begin
          nxt.llc_snap_match = state.llc_snap_match && (b == LLC_CTRL);
          nxt.l2_phase = (state.llc_snap_match && (b == LLC_CTRL)) ? PH_SNAP : PH_DONE;
        end
      end
      PH_SNAP: begin
        if (k >= 8'd3 && k <= 8'd5 && b != SNAP_ZERO) nxt.llc_snap_match = 1'b0;
        if (k == 8'd6 && state.llc_snap_match) nxt.ether_type = {b, 8'h00};
        if (k == 8'd7) begin
          if (state.llc_snap_match) begin
            nxt.ether_type   = type_low;
            nxt.header_start = state.header_start + SNAP_LEN;
          end
          nxt.l2_phase = PH_DONE;
        end
      end
      default: begin
        if (state.ether_type == ET_IPV4) begin
          if (k == 8'd0) nxt.ip_header_bytes = {b[3:0], 2'b00};
          if (k == 8'd9) nxt.l4_protocol = b;
        end else if (state.ether_type == ET_IPV6) begin
          if (k == 8'd6) nxt.l4_protocol = b;
        end
      end
    endcase
    nxt.byte_offset = (p != 8'hFF) ? p + 8'd1 : p;
  end

  always_comb begin
    fresh            = '0;
    fresh.held_queue = nxt.held_queue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (fire) begin
      if (item.last_byte) begin
        state <= fresh;
      end else begin
        state <= nxt;
      end
    end
  end

endmodule

`default_nettype wire

[sv/pkf_judge.sv]
`default_nettype none

module pkf_judge
  import pkf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       load,
  input  wire pkf_state_t s,
  input  wire cfg_t       cfg,
  input  wire logic       out_stall,
  output logic            out_valid,
  output out_word_t       out_data,
  output logic            busy
);

  logic [8:0] len;
  logic [8:0] hs;
  logic [8:0] ihl;
  logic [8:0] l4_start;
  logic [8:0] need;
  logic [4:0] l4_bit;
  logic       is_v4;
  logic       is_v6;
  logic       is_arp;
  logic       m2;
  logic       m3;
  logic       m4;
  logic       hdr_bad;
  logic       l4_pass;
  logic       bound;
  logic       verdict;

  assign len    = {1'b0, s.byte_offset};
  assign hs     = {2'b00, s.header_start};
  assign ihl    = {3'b000, s.ip_header_bytes};
  assign is_v4  = (s.ether_type == ET_IPV4);
  assign is_v6  = (s.ether_type == ET_IPV6);
  assign is_arp = (s.ether_type == ET_ARP);

  always_comb begin
    case (s.l4_protocol)
      PROTO_TCP: begin
        l4_bit = L4_TCP;
        need   = 9'd20;
      end
      PROTO_UDP: begin
        l4_bit = L4_UDP;
        need   = 9'd8;
      end
      PROTO_ICMP: begin
        l4_bit = is_v6 ? L4_OTHER : L4_ICMP;
        need   = is_v6 ? 9'd0 : 9'd8;
      end
      PROTO_ICMPV6: begin
        l4_bit = is_v6 ? L4_ICMPV6 : L4_OTHER;
        need   = is_v6 ? 9'd8 : 9'd0;
      end
      default: begin
        l4_bit = L4_OTHER;
        need   = 9'd0;
      end
    endcase
  end

  assign l4_start = is_v4 ? hs + ihl : hs + 9'd40;
  assign hdr_bad  = is_v4 ? (len < hs + 9'd20 || ihl < 9'd20 || len < hs + ihl)
                          : (len < hs + 9'd40);
  assign l4_pass  = ((cfg.layer4_mask & l4_bit) != 5'd0) && (len >= l4_start + need);

  always_comb begin
    m2 = 1'b1;
    if (cfg.layer2_mask != 3'd0) begin
      if (is_arp && !cfg.layer2_mask[2]) m2 = 1'b0;
      if (s.vlan_seen ? !cfg.layer2_mask[1] : !cfg.layer2_mask[0]) m2 = 1'b0;
    end
    m3 = m2;
    if (m2 && cfg.layer3_mask != 3'd0 && !is_arp) begin
      if (is_v4)      m3 = cfg.layer3_mask[0];
      else if (is_v6) m3 = cfg.layer3_mask[1];
      else            m3 = cfg.layer3_mask[2];
    end
    m4 = m3;
    if (m3 && cfg.layer4_mask != 5'd0 && (is_v4 || is_v6)) begin
      m4 = !hdr_bad && l4_pass;
    end
  end

  assign bound = ({1'b0, s.held_queue} < 7'(QUEUE_COUNT)) &&
                 cfg.socket_bound_mask[s.held_queue];

  assign verdict = cfg.filter_enable && (s.l2_phase == PH_DONE) &&
                   ({cfg.layer2_mask, cfg.layer3_mask, cfg.layer4_mask} != 11'd0) &&
                   m4 && bound;

  assign busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.verdict     <= verdict;
      out_data.queue_index <= s.held_queue;
    end
  end

endmodule

`default_nettype wire

[sv/ethernet_l2_l3_l4_packet_filter_unit.sv]
// Channel   Direction  Handshake             Word
// in        input      in_valid / in_stall   in_word_t: data_byte, last_byte, rx_queue
// out       output     out_valid / out_stall out_word_t: verdict, queue_index
// cfg       input      APB, pready tied high 64-bit registers at 8 * index
//
// One byte is taken every cycle while in_stall is low; each goes through the input register.
// The verdict is registered in the output register once the held last byte is parsed.
// Reset is synchronous and active high; it clears valid flags, parser state and config masks.
// A stalled result holds only the next last byte in the input register; others keep flowing.
`default_nettype none

module ethernet_l2_l3_l4_packet_filter_unit
  import pkf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_word_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_word_t        out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready
);

  cfg_t       cfg;
  pkf_state_t nxt;
  in_word_t   held;
  logic       held_valid;
  logic       busy;
  logic       fire;

  assign fire     = held_valid && !(held.last_byte && busy);
  assign in_stall = held_valid && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      held <= in_data;
    end
  end

  pkf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pkf_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (held),
    .nxt  (nxt)
  );

  pkf_judge u_judge (
    .clk       (clk),
    .rst       (rst),
    .load      (fire && held.last_byte),
    .s         (nxt),
    .cfg       (cfg),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .busy      (busy)
  );

endmodule

`default_nettype wire

[sv/pkf_check.sv]
`default_nettype none

`include "ethernet_l2_l3_l4_packet_filter_unit_macros.svh"

module pkf_check
  import pkf_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_word_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_word_t out_data,
  input wire logic      pready
);

  // Input back-pressure only ever comes from a result that is stuck at the output.
  `PKF_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

  // A fresh result follows a last byte taken at the input and passed through the input register.
  `PKF_ASSERT_NOW(a_result_source, $rose(out_valid),
    $past(in_valid && !in_stall && in_data.last_byte, 2))

  // A stalled result stays put.
  `PKF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // The register port never inserts wait states.
  `PKF_ASSERT_NOW(a_pready, 1'b1, pready)

endmodule

bind ethernet_l2_l3_l4_packet_filter_unit pkf_check u_check (.*);

`default_nettype wire
